// File: design/phc_pkg.sv
// ----------------------------------------------------------------------------
// phc_pkg
// Types, class codes and digit rule functions for the hadron classifier.
// ----------------------------------------------------------------------------
package phc_pkg;

  typedef logic [3:0] digit_t;
  typedef digit_t [9:0] digits_t;

  typedef enum logic [3:0] {
    CLS_UNKNOWN   = 4'd0,
    CLS_BB_MESON  = 4'd1,
    CLS_CC_MESON  = 4'd2,
    CLS_B_MESON   = 4'd3,
    CLS_C_MESON   = 4'd4,
    CLS_B_BARYON  = 4'd5,
    CLS_C_BARYON  = 4'd6,
    CLS_S_BARYON  = 4'd7,
    CLS_L_BARYON  = 4'd8,
    CLS_S_MESON   = 4'd9,
    CLS_L_MESON   = 4'd10
  } hclass_t;

  localparam logic [15:0] QUARK_TOP = 16'd60001;

  typedef struct packed {
    logic    vld;
    logic    neg;
    logic [31:0] bin;
    digits_t bcd;
  } dd_t;

  typedef struct packed {
    logic [15:0] lead;
    logic        quark;
    logic        mes;
    logic        diq;
    logic        bar;
    logic        tet;
    logic        pen;
  } rule_t;

  function automatic logic [3:0] f_nd(digits_t d);
    logic [3:0] n;
    n = 4'd0;
    for (int k = 0; k < 10; k++) begin
      if (d[k] != 4'd0) n = 4'(k + 1);
    end
    return n;
  endfunction

  // i-th digit from the top, zero beyond the length
  function automatic digit_t f_td(digits_t d, logic [3:0] n, int i);
    digit_t r;
    r = 4'd0;
    for (int k = 0; k < 10; k++) begin
      if (k == int'(n) - 1 - i) r = d[k];
    end
    return r;
  endfunction

  function automatic digit_t f_maxr(digits_t d, int m, int n);
    digit_t r;
    r = 4'd0;
    for (int k = m; k < n; k++) begin
      if (d[k] > r) r = d[k];
    end
    return r;
  endfunction

  function automatic digit_t f_minr(digits_t d, int m, int n);
    digit_t r;
    r = 4'd9;
    for (int k = m; k < n; k++) begin
      if (d[k] < r) r = d[k];
    end
    return r;
  endfunction

  function automatic logic f_quark(digits_t d);
    return (d[9:1] == '0 && d[0] != 4'd0 && d[0] <= 4'd8) ||
           (d[9:5] == '0 && d[4] == 4'd6 && d[3:1] == '0 && d[0] == 4'd1);
  endfunction

  function automatic logic f_meson(digits_t d, logic neg);
    logic [3:0] n;
    digit_t mx;
    n  = f_nd(d);
    mx = f_maxr(d, 1, 3);
    if (n < 4'd3) return 1'b0;
    if (n == 4'd7 && (f_td(d, n, 0) == 4'd1 || f_td(d, n, 0) == 4'd2)) return 1'b0;
    // neutral kaon codes
    if (d[9:3] == '0 && ((d[2] == 4'd3 && d[1] == 4'd1 && d[0] == 4'd0) ||
        (d[2] == 4'd1 && d[1] == 4'd3 && d[0] == 4'd0) ||
        (d[2] == 4'd3 && d[1] == 4'd1 && d[0] == 4'd1))) return 1'b1;
    if (!d[0][0]) return 1'b0;
    if (mx >= 4'd6 || mx == 4'd0) return 1'b0;
    if (n > 4'd3 && d[3] != 4'd0) return 1'b0;
    if (neg) begin
      if (n == 4'd3 && f_td(d, n, 0) == f_td(d, n, 1)) return 1'b0;
      if (n == 4'd5 && f_td(d, n, 2) == f_td(d, n, 3)) return 1'b0;
      if (n == 4'd7 && f_td(d, n, 4) == f_td(d, n, 5)) return 1'b0;
    end
    if (n == 4'd3 && f_td(d, n, 0) >= f_td(d, n, 1) && f_td(d, n, 1) != 4'd0) return 1'b1;
    if (n == 4'd5 && f_td(d, n, 2) >= f_td(d, n, 3) && f_td(d, n, 3) != 4'd0 &&
        f_td(d, n, 1) == 4'd0) begin
      if (f_td(d, n, 0) == 4'd1) return 1'b1;
      if ((f_td(d, n, 0) == 4'd2 || f_td(d, n, 0) == 4'd3) && d[0] > 4'd1) return 1'b1;
    end
    if (n == 4'd6 && f_td(d, n, 3) >= f_td(d, n, 4) && f_td(d, n, 4) != 4'd0) return 1'b1;
    if (n == 4'd7 && f_td(d, n, 0) == 4'd9 && f_td(d, n, 1) == 4'd0 &&
        f_td(d, n, 4) >= f_td(d, n, 5) && f_td(d, n, 5) != 4'd0) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic f_baryon(digits_t d);
    logic [3:0] n;
    digit_t a, b, l;
    n = f_nd(d);
    a = f_td(d, n, 0);
    b = f_td(d, n, 1);
    l = d[0];
    if (n < 4'd4) return 1'b0;
    if (f_maxr(d, 1, 4) >= 4'd6 || f_minr(d, 1, 4) == 4'd0) return 1'b0;
    if (n == 4'd4) return l == 4'd2 || l == 4'd4 || l == 4'd6 || l == 4'd8;
    if (n == 4'd5) begin
      if ((a == 4'd1 || a == 4'd3) && (l == 4'd2 || l == 4'd4)) return 1'b1;
      if (a == 4'd2 && (l == 4'd2 || l == 4'd4 || l == 4'd6)) return 1'b1;
      if ((a == 4'd5 || a == 4'd4) && l == 4'd2) return 1'b1;
      if (a == 4'd1 && l == 4'd6) return 1'b1;
      return 1'b0;
    end
    if (n == 4'd6) begin
      if (a == 4'd1 && b == 4'd0 && (l == 4'd2 || l == 4'd4 || l == 4'd6)) return 1'b1;
      if (a == 4'd1 && b == 4'd1 && l == 4'd2) return 1'b1;
      if (a == 4'd1 && b == 4'd2 && l == 4'd4) return 1'b1;
      if (a == 4'd2 && b == 4'd0 &&
          (l == 4'd2 || l == 4'd4 || l == 4'd6 || l == 4'd8)) return 1'b1;
      if (a == 4'd2 && b == 4'd1 && l == 4'd2) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic f_tetra(digits_t d);
    logic [3:0] n;
    n = f_nd(d);
    return n == 4'd9 && f_td(d, n, 0) == 4'd1 && f_td(d, n, 5) == 4'd0 &&
           f_maxr(d, 1, 3) <= 4'd6 && f_minr(d, 1, 3) > 4'd0 &&
           f_maxr(d, 4, 6) <= 4'd6 && f_minr(d, 4, 6) > 4'd0 &&
           f_td(d, n, 3) >= f_td(d, n, 4) && f_td(d, n, 6) >= f_td(d, n, 7) &&
           (f_td(d, n, 3) > f_td(d, n, 6) ||
            (f_td(d, n, 3) == f_td(d, n, 6) && f_td(d, n, 4) >= f_td(d, n, 7)));
  endfunction

  function automatic logic f_penta(digits_t d);
    logic [3:0] n;
    n = f_nd(d);
    return n == 4'd9 && f_td(d, n, 0) == 4'd1 && f_maxr(d, 1, 6) <= 4'd6 &&
           f_minr(d, 1, 6) > 4'd0 && f_td(d, n, 3) >= f_td(d, n, 4) &&
           f_td(d, n, 4) >= f_td(d, n, 5) && f_td(d, n, 5) >= f_td(d, n, 6);
  endfunction

  function automatic logic f_diquark(digits_t d);
    logic [3:0] n;
    n = f_nd(d);
    return n == 4'd4 && f_td(d, n, 0) >= f_td(d, n, 1) && f_td(d, n, 2) == 4'd0 &&
           d[0][0] && f_maxr(d, 2, 4) <= 4'd6;
  endfunction

  function automatic rule_t f_rules(digits_t d, logic neg);
    rule_t r;
    r.quark = f_quark(d);
    r.mes   = f_meson(d, neg);
    r.diq   = f_diquark(d);
    r.bar   = f_baryon(d);
    r.tet   = f_tetra(d);
    r.pen   = f_penta(d);
    if (r.quark) r.lead = (d[9:1] == '0) ? {12'd0, d[0]} : QUARK_TOP;
    else if (r.mes) r.lead = {12'd0, f_maxr(d, 1, 3)};
    else if (r.diq) r.lead = {12'd0, f_maxr(d, 2, 4)};
    else if (r.bar) r.lead = {12'd0, f_maxr(d, 1, 4)};
    else if (r.tet) r.lead = {12'd0, f_maxr(d, 1, 5)};
    else if (r.pen) r.lead = {12'd0, f_maxr(d, 1, 6)};
    else r.lead = 16'd0;
    return r;
  endfunction

  function automatic logic f_gen_range(logic [16:0] p);
    return (p >= 17'd81 && p <= 17'd100) || (p >= 17'd901 && p <= 17'd930) ||
           (p >= 17'd998 && p <= 17'd999) || (p >= 17'd1901 && p <= 17'd1930) ||
           (p >= 17'd2901 && p <= 17'd2930) || (p >= 17'd3901 && p <= 17'd3930);
  endfunction

endpackage

// File: design/phc_in_if.sv
// ----------------------------------------------------------------------------
// phc_in_if
// Input channel: one signed particle code per beat.
// ----------------------------------------------------------------------------
interface phc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] particle_code;

  modport source (output valid, output particle_code, input ready);
  modport sink   (input valid, input particle_code, output ready);
endinterface

// File: design/phc_out_if.sv
// ----------------------------------------------------------------------------
// phc_out_if
// Output channel: hadron class, hadron flag and leading quark per beat.
// ----------------------------------------------------------------------------
interface phc_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  hadron_class;
  logic        is_hadron;
  logic [15:0] leading_quark;

  modport source (output valid, output hadron_class, output is_hadron,
                  output leading_quark, input ready);
  modport sink   (input valid, input hadron_class, input is_hadron,
                  input leading_quark, output ready);
endinterface

// File: design/phc_dd_stage.sv
// ----------------------------------------------------------------------------
// phc_dd_stage
// Registered binary to decimal stage: eight shift-add-3 steps per cycle while en is high.
// ----------------------------------------------------------------------------
module phc_dd_stage (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  phc_pkg::dd_t din,
  output phc_pkg::dd_t dout
);
  import phc_pkg::*;

  dd_t dout_next;

  always_comb begin
    dout_next = din;
    for (int s = 0; s < 8; s++) begin
      for (int k = 0; k < 10; k++) begin
        if (dout_next.bcd[k] >= 4'd5) dout_next.bcd[k] = dout_next.bcd[k] + 4'd3;
      end
      {dout_next.bcd, dout_next.bin} = {dout_next.bcd, dout_next.bin} << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) dout.vld <= 1'b0;
    else if (en) dout <= dout_next;
  end

endmodule

// File: design/particle_code_hadron_classifier.sv
// ----------------------------------------------------------------------------
// particle_code_hadron_classifier
// An accepted code passes through the input register, the four binary to
// decimal stages, the rule stage and the output register to its result beat.
// Throughput one code per cycle; the whole pipeline holds while the output beat waits.
// Synchronous active-high reset clears all stage valid bits; no other state.
// ----------------------------------------------------------------------------
module particle_code_hadron_classifier (
  input logic clk,
  input logic rst,
  phc_in_if.sink    code,
  phc_out_if.source result
);
  import phc_pkg::*;

  logic    adv;
  dd_t     dd_in;
  dd_t     dd [0:4];

  // rule stage
  logic    v5;
  rule_t   outer, inner;
  logic    susy;
  digit_t  d1, d2;

  // output register
  logic        out_v;
  hclass_t     cls;
  logic        hadron;
  logic [15:0] lq;

  assign adv        = !out_v || result.ready;
  assign code.ready = adv;

  // magnitude and sign, most negative code taken as its neighbour
  always_ff @(posedge clk) begin
    if (rst) begin
      dd_in.vld <= 1'b0;
    end else if (adv) begin
      dd_in.vld <= code.valid;
      dd_in.neg <= code.particle_code[31];
      dd_in.bcd <= '0;
      if (code.particle_code == 32'sh8000_0000) dd_in.bin <= 32'h7fff_ffff;
      else if (code.particle_code[31]) dd_in.bin <= 32'(-code.particle_code);
      else dd_in.bin <= 32'(code.particle_code);
    end
  end

  assign dd[0] = dd_in;

  for (genvar g = 0; g < 4; g++) begin : g_dd
    phc_dd_stage u_dd (
      .clk  (clk),
      .rst  (rst),
      .en   (adv),
      .din  (dd[g]),
      .dout (dd[g+1])
    );
  end

  // rules on the full code and on the supersymmetric remainder
  digits_t     dg, pp, ppv;
  logic [3:0]  ppnd;
  logic        ppneg;
  logic [16:0] low5;

  always_comb begin
    dg    = dd[4].bcd;
    pp    = dg;
    pp[9] = 4'd0;
    pp[8] = 4'd0;
    pp[7] = 4'd0;
    pp[6] = 4'd0;
    ppnd  = f_nd(pp);
    ppv   = '0;
    ppneg = dd[4].neg;
    if (ppnd == 4'd3) begin
      ppv[0] = pp[1];
      ppneg  = 1'b0;
    end else if (ppnd > 4'd3) begin
      ppv = pp;
      for (int k = 0; k < 10; k++) begin
        if (k == int'(ppnd) - 1) ppv[k] = 4'd0;
      end
    end
    low5 = 17'(dg[4]) * 17'd10000 + 17'(dg[3]) * 17'd1000 + 17'(dg[2]) * 17'd100 +
           17'(dg[1]) * 17'd10 + 17'(dg[0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5    <= dd[4].vld;
      outer <= f_rules(dg, dd[4].neg);
      inner <= f_rules(ppv, ppneg);
      susy  <= f_nd(dg) == 4'd7 && (dg[6] == 4'd1 || dg[6] == 4'd2) &&
               !(!dd[4].neg && f_gen_range(low5));
      d1    <= dg[1];
      d2    <= dg[2];
    end
  end

  // class selection
  logic        hit;
  logic [15:0] lq_next;
  hclass_t     cls_next;

  always_comb begin
    hit     = outer.quark || outer.mes || outer.diq || outer.bar || outer.tet || outer.pen;
    lq_next = hit ? outer.lead : (susy ? inner.lead : 16'd0);
    if (outer.mes && lq_next == 16'd5 && d2 == 4'd5 && d1 == 4'd5) cls_next = CLS_BB_MESON;
    else if (outer.mes && lq_next == 16'd4 && d2 == 4'd4 && d1 == 4'd4) cls_next = CLS_CC_MESON;
    else if (outer.mes && lq_next == 16'd5) cls_next = CLS_B_MESON;
    else if (outer.mes && lq_next == 16'd4) cls_next = CLS_C_MESON;
    else if (outer.bar && lq_next == 16'd5) cls_next = CLS_B_BARYON;
    else if (outer.bar && lq_next == 16'd4) cls_next = CLS_C_BARYON;
    else if (outer.bar && lq_next == 16'd3) cls_next = CLS_S_BARYON;
    else if (outer.bar && (lq_next == 16'd1 || lq_next == 16'd2)) cls_next = CLS_L_BARYON;
    else if (outer.mes && lq_next == 16'd3) cls_next = CLS_S_MESON;
    else if (outer.mes && (lq_next == 16'd1 || lq_next == 16'd2)) cls_next = CLS_L_MESON;
    else cls_next = CLS_UNKNOWN;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (adv) begin
      out_v  <= v5;
      cls    <= cls_next;
      hadron <= outer.mes || outer.bar || outer.tet || outer.pen;
      lq     <= lq_next;
    end
  end

  assign result.valid         = out_v;
  assign result.hadron_class  = cls;
  assign result.is_hadron     = hadron;
  assign result.leading_quark = lq;

  a_class_hadron: assert property (@(posedge clk) disable iff (rst)
    out_v && cls != CLS_UNKNOWN |-> hadron)
    else $error("classified beat without hadron flag");

  a_class_quark: assert property (@(posedge clk) disable iff (rst)
    out_v && cls != CLS_UNKNOWN |-> lq >= 16'd1 && lq <= 16'd5)
    else $error("classified beat with odd leading quark");

  a_onium: assert property (@(posedge clk) disable iff (rst)
    out_v && (cls == CLS_BB_MESON || cls == CLS_B_MESON || cls == CLS_B_BARYON)
    |-> lq == 16'd5)
    else $error("bottom class without bottom quark");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_v && !result.ready |=> out_v && $stable(lq) && $stable(cls))
    else $error("stalled result changed");

endmodule
